// ----- sv/rsa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rsa_pkg
// shared types, constants and command/status structs for the running
// statistics accumulator
// ----------------------------------------------------------------------------
package rsa_pkg;

	localparam int FracBits = 16;

	typedef struct packed {
		logic [31:0] sample;
		logic        skip_flush;
		logic [30:0] frame_number;
	} in_item_t;

	typedef struct packed {
		logic [31:0] sample_total;
		logic [31:0] lowest;
		logic [31:0] highest;
		logic [31:0] average;
		logic [30:0] deviation;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture input, update count/min/max, start mean divide
		logic div_step;   // one quotient bit
		logic mean_upd;   // apply quotient to mean
		logic mul;        // form product of deviations
		logic acc;        // accumulate m2
		logic flush_div;  // start m2/count divide
		logic sqrt_init;  // start root
		logic sqrt_step;  // one root digit
		logic emit;       // load output register, clear stats
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic flush;
	} sts_t;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_DIV   = 9'b000000010,
		ST_MEAN  = 9'b000000100,
		ST_MUL   = 9'b000001000,
		ST_ACC   = 9'b000010000,
		ST_FDIV  = 9'b000100000,
		ST_SQI   = 9'b001000000,
		ST_SQRT  = 9'b010000000,
		ST_OUT   = 9'b100000000
	} state_t;

endpackage
`default_nettype wire

// ----- sv/running_statistics_accumulator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// running_statistics_accumulator
// online count, min, max, welford mean and population deviation of Q16.16
// samples; one record per flush request
// ----------------------------------------------------------------------------
//  channel | direction | payload            | handshake
//  in      | input     | rsa_pkg::in_item_t  | in_valid / in_stall
//  out     | output    | rsa_pkg::out_item_t | out_valid / out_stall
//
// a request without flush runs accept, the serial mean divider, update, multiply
// and accumulate; a flushing request adds the m2 divide (load and 64 steps),
// the serial root and a load of the output register
// reset clears statistics, last flush frame and output valid
// the result sits in an output register; a new request is taken while it waits,
// but the next flush holds until it is taken
// ----------------------------------------------------------------------------
module running_statistics_accumulator (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire rsa_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output rsa_pkg::out_item_t      out_data
);

	rsa_pkg::cmd_t     cmd;
	rsa_pkg::sts_t     sts;
	rsa_pkg::in_item_t item_q;
	logic              first_cnt;

	// hold the request for the frame number at emit
	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= in_data;
	end

	rsa_control u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd),
		.first_cnt(first_cnt)
	);

	rsa_datapath u_dp (
		.clk      (clk),
		.in_item  (cmd.load ? in_data : item_q),
		.cmd      (cmd),
		.first_cnt(first_cnt),
		.sts      (sts),
		.result   (out_data),
		.arst_n   (arst_n)
	);

endmodule
`default_nettype wire

// ----- sv/rsa_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rsa_datapath
// statistics registers, shared serial divider, multiplier and serial root
// ----------------------------------------------------------------------------
module rsa_datapath (
	input  wire logic              clk,
	input  wire rsa_pkg::in_item_t in_item,
	input  wire rsa_pkg::cmd_t     cmd,
	input  wire logic              first_cnt,
	output rsa_pkg::sts_t          sts,
	output rsa_pkg::out_item_t     result,
	input  wire logic              arst_n
);

	logic [31:0] tally_q, min_q, max_q, mean_q;
	logic [63:0] m2_q;
	logic [30:0] last_frame_q;
	logic [31:0] x_q;
	logic        flush_q;
	logic        neg_q;
	logic [32:0] delta_q;     // signed delta, 33 bits
	logic [63:0] quo_q, rem_q, dvd_q;
	logic [63:0] prod_q;
	logic [63:0] sq_v_q, sq_root_q, sq_bit_q;
	logic [31:0] mean_new;
	logic [32:0] d2;
	logic [32:0] mag1, mag2;
	logic [64:0] sum;
	logic [64:0] trial;
	logic [63:0] rb;
	logic [63:0] dev;

	assign sts.flush = flush_q;
	assign mag1 = delta_q[32] ? 33'(-delta_q) : delta_q;
	assign d2   = {x_q[31], x_q} - {mean_new[31], mean_new};
	assign mag2 = d2[32] ? 33'(-d2) : d2;
	assign mean_new = mean_q;
	assign sum  = {1'b0, m2_q} + {1'b0, prod_q};
	assign trial = {1'b0, rem_q[62:0], dvd_q[63]} - {33'd0, tally_q};
	assign rb   = sq_root_q + sq_bit_q;
	assign dev  = sq_root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_q      <= '0;
			min_q        <= '0;
			max_q        <= '0;
			mean_q       <= '0;
			m2_q         <= '0;
			last_frame_q <= '0;
			flush_q      <= 1'b0;
		end else if (cmd.load) begin
			flush_q <= !in_item.skip_flush && (in_item.frame_number > last_frame_q);
			if (tally_q == '0) begin
				min_q <= in_item.sample;
				max_q <= in_item.sample;
			end else begin
				if ($signed(in_item.sample) < $signed(min_q)) min_q <= in_item.sample;
				if ($signed(in_item.sample) > $signed(max_q)) max_q <= in_item.sample;
			end
			if (tally_q != '1) tally_q <= tally_q + 32'd1;
		end else if (cmd.mean_upd) begin
			mean_q <= neg_q ? 32'(mean_q - quo_q[31:0]) : 32'(mean_q + quo_q[31:0]);
		end else if (cmd.acc) begin
			m2_q <= sum[64] ? '1 : sum[63:0];
		end else if (cmd.emit) begin
			last_frame_q <= in_item.frame_number;
			tally_q <= '0;
			min_q   <= '0;
			max_q   <= '0;
			mean_q  <= '0;
			m2_q    <= '0;
		end
	end

	// sample, delta, product and result stages carry no reset
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q     <= in_item.sample;
			delta_q <= {in_item.sample[31], in_item.sample} - {mean_q[31], mean_q};
		end
		if (cmd.mul) prod_q <= 64'(mag1) * 64'(mag2);
		// restoring divider by tally, one bit per step
		if (first_cnt && cmd.div_step) begin
			// first step of mean divide: set up from delta magnitude
			dvd_q <= {31'd0, mag1} << 31;
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= delta_q[32];
		end else if (cmd.flush_div) begin
			dvd_q <= m2_q;
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[62:0], 1'b0};
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], dvd_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
		// bitwise integer square root, one digit per step
		if (cmd.sqrt_init) begin
			sq_v_q    <= quo_q;
			sq_root_q <= '0;
			sq_bit_q  <= 64'd1 << 62;
		end else if (cmd.sqrt_step) begin
			if (sq_v_q >= rb) begin
				sq_v_q    <= sq_v_q - rb;
				sq_root_q <= (sq_root_q >> 1) + sq_bit_q;
			end else begin
				sq_root_q <= sq_root_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end
		if (cmd.emit) begin
			result.sample_total <= tally_q;
			result.lowest       <= min_q;
			result.highest      <= max_q;
			result.average      <= mean_q;
			result.deviation    <= (dev > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : dev[30:0];
		end
	end

endmodule
`default_nettype wire

// ----- sv/rsa_control.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rsa_control
// sequencer for one sample: divide, update, multiply, accumulate, optional flush
// ----------------------------------------------------------------------------
module rsa_control (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  wire logic          out_stall,
	input  wire rsa_pkg::sts_t sts,
	output rsa_pkg::cmd_t      cmd,
	output logic               first_cnt
);

	rsa_pkg::state_t state_q, state_d;
	logic [5:0] cnt_q;
	logic       out_valid_q;

	assign out_valid = out_valid_q;
	assign in_stall  = (state_q != rsa_pkg::ST_IDLE);
	assign first_cnt = (cnt_q == 6'd0) && (state_q == rsa_pkg::ST_DIV);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			rsa_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = rsa_pkg::ST_DIV;
				end
			end
			rsa_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == 6'd33) state_d = rsa_pkg::ST_MEAN;
			end
			rsa_pkg::ST_MEAN: begin
				cmd.mean_upd = 1'b1;
				state_d = rsa_pkg::ST_MUL;
			end
			rsa_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = rsa_pkg::ST_ACC;
			end
			rsa_pkg::ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = sts.flush ? rsa_pkg::ST_FDIV : rsa_pkg::ST_IDLE;
			end
			rsa_pkg::ST_FDIV: begin
				if (cnt_q == 6'd0) cmd.flush_div = 1'b1;
				else cmd.div_step = 1'b1;
				if (cnt_q == 6'd63) state_d = rsa_pkg::ST_SQI;
			end
			rsa_pkg::ST_SQI: begin
				cmd.div_step = 1'b1; // last quotient bit
				state_d = rsa_pkg::ST_SQRT;
			end
			rsa_pkg::ST_SQRT: begin
				if (cnt_q == 6'd0) cmd.sqrt_init = 1'b1;
				else cmd.sqrt_step = 1'b1;
				if (cnt_q == 6'd32) state_d = rsa_pkg::ST_OUT;
			end
			rsa_pkg::ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.emit = 1'b1;
					state_d = rsa_pkg::ST_IDLE;
				end
			end
			default: state_d = rsa_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rsa_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? 6'd0 : 6'(cnt_q + 6'd1);
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire
